// ===== sv/mrrc_pkg.sv =====
`default_nettype none

package mrrc_pkg;

	// Frame limits
	localparam int MAX_FRAME_BYTES = 256;
	localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CMP_W           = ((IDX_W > 8) ? IDX_W : 8) + 2;

	// CRC-16, reflected form
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Function code of an exception response to a register read
	localparam logic [7:0] FUNC_EXCEPTION = 8'h83;

	// Result bus layout
	localparam int TDATA_W = 32;

	// Register indexes of the configuration port
	localparam logic CFG_SLAVE    = 1'b0;
	localparam logic CFG_FUNCTION = 1'b1;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_TOO_SHORT     = 3'd1,
		ST_CRC_BAD       = 3'd2,
		ST_SLAVE_BAD     = 3'd3,
		ST_EXCEPTION     = 3'd4,
		ST_PAYLOAD_SHORT = 3'd5,
		ST_OVERFLOW      = 3'd6
	} status_t;

	// Fold one octet into the running CRC, one bit per step
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] octet);
		logic [15:0] c;
		c = crc ^ {8'h00, octet};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/modbus_rtu_response_checker.sv =====
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: rx_byte; tlast: end_of_frame
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: is_status; tdata: result fields
// cfg       in         cfg_we (no wait)              cfg_index selects register, cfg_data
//
// One item per cycle sustained unless the output stalls: an input register (_s1) feeds
// the CRC fold, header checks and status selection, which load the result register in
// the same cycle. An accepted item passes the input register, then the result register;
// an item that yields no result is absorbed without touching the output. Reset clears
// all frame state and sets expected_slave to 1 and expected_function to 3. When the
// output stalls, the input register holds and s_axis_tready drops in the same cycle.
`default_nettype none

module modbus_rtu_response_checker
	import mrrc_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	// stream in
	input  wire                 s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire  [7:0]          s_axis_tdata,   // [7:0] rx_byte
	input  wire                 s_axis_tlast,   // end_of_frame
	// stream out
	output logic                m_axis_tvalid,
	input  wire                 m_axis_tready,
	output logic [TDATA_W-1:0]  m_axis_tdata,   // [7:0] payload_byte, [10:8] frame_status,
	                                            // [18:11] exception_code,
	                                            // [19] function_mismatch,
	                                            // [27:20] payload_length, [31:28] zero
	output logic                m_axis_tuser,   // [0] is_status
	// configuration
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [7:0]          cfg_data
);

	// Configuration registers
	logic [7:0] exp_slave_q;
	logic [7:0] exp_function_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame state
	logic [15:0]      crc_q;
	logic [IDX_W-1:0] byte_index_q;
	logic [7:0]       dly0_q;
	logic [7:0]       dly1_q;
	logic [7:0]       hdr_slave_q;
	logic [7:0]       hdr_function_q;
	logic [7:0]       hdr_count_q;
	logic             overflow_q;

	// Result register
	logic               res_valid_q;
	logic [TDATA_W-1:0] res_data_q;
	logic               res_user_q;

	// Combinational next values
	logic               out_free;
	logic               fire_s1;
	logic               over_now;
	logic [15:0]        crc_n;
	logic [IDX_W-1:0]   index_n;
	logic [7:0]         dly0_n;
	logic [7:0]         dly1_n;
	logic [7:0]         hs_n;
	logic [7:0]         hf_n;
	logic [7:0]         hc_n;
	logic               emit_payload;
	logic               produce;
	status_t            status;
	logic [7:0]         exc_code;
	logic               func_mis;
	logic [7:0]         pay_len;
	logic [TDATA_W-1:0] res_data_n;

	// Handshake: the input register moves whenever the result slot is free
	assign out_free      = !res_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_data_q;
	assign m_axis_tuser  = res_user_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_slave_q    <= 8'd1;
			exp_function_q <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLAVE:    exp_slave_q    <= cfg_data;
				CFG_FUNCTION: exp_function_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Advance frame state for the registered item
	always_comb begin
		over_now     = (byte_index_q >= IDX_W'(MAX_FRAME_BYTES));
		crc_n        = crc_q;
		index_n      = byte_index_q;
		dly0_n       = dly0_q;
		dly1_n       = dly1_q;
		hs_n         = hdr_slave_q;
		hf_n         = hdr_function_q;
		hc_n         = hdr_count_q;
		emit_payload = 1'b0;
		if (!over_now) begin
			if (byte_index_q >= IDX_W'(2)) begin
				crc_n = crc_fold(crc_q, dly1_q);
			end
			dly1_n  = dly0_q;
			dly0_n  = byte_s1;
			index_n = byte_index_q + IDX_W'(1);
			priority if (byte_index_q == IDX_W'(0)) begin
				hs_n = byte_s1;
			end else if (byte_index_q == IDX_W'(1)) begin
				hf_n = byte_s1;
			end else if (byte_index_q == IDX_W'(2)) begin
				hc_n = byte_s1;
			end else begin
				emit_payload = (CMP_W'(byte_index_q) < CMP_W'(hdr_count_q) + CMP_W'(3))
				               && (hdr_function_q != FUNC_EXCEPTION);
			end
		end
	end

	// Pick the frame status in priority order
	always_comb begin
		status   = ST_OK;
		exc_code = 8'h00;
		func_mis = 1'b0;
		pay_len  = 8'h00;
		priority if (overflow_q || over_now) begin
			status = ST_OVERFLOW;
		end else if (index_n < IDX_W'(4)) begin
			status = ST_TOO_SHORT;
		end else if (dly1_n != crc_n[7:0] || byte_s1 != crc_n[15:8]) begin
			status = ST_CRC_BAD;
		end else if (index_n < IDX_W'(5)) begin
			status = ST_TOO_SHORT;
		end else if (hs_n != exp_slave_q) begin
			status = ST_SLAVE_BAD;
		end else if (hf_n == FUNC_EXCEPTION) begin
			status   = ST_EXCEPTION;
			exc_code = hc_n;
		end else begin
			func_mis = (hf_n != exp_function_q);
			if (CMP_W'(hc_n) + CMP_W'(5) > CMP_W'(index_n)) begin
				status = ST_PAYLOAD_SHORT;
			end else begin
				pay_len = hc_n;
			end
		end
	end

	// Pack the result
	always_comb begin
		res_data_n = '0;
		if (last_s1) begin
			res_data_n[10:8]  = status;
			res_data_n[18:11] = exc_code;
			res_data_n[19]    = func_mis;
			res_data_n[27:20] = pay_len;
		end else begin
			res_data_n[7:0] = byte_s1;
		end
	end

	assign produce = last_s1 || emit_payload;

	// Update frame state; clear it after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q          <= CRC_SEED;
			byte_index_q   <= '0;
			dly0_q         <= 8'h00;
			dly1_q         <= 8'h00;
			hdr_slave_q    <= 8'h00;
			hdr_function_q <= 8'h00;
			hdr_count_q    <= 8'h00;
			overflow_q     <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				crc_q          <= CRC_SEED;
				byte_index_q   <= '0;
				dly0_q         <= 8'h00;
				dly1_q         <= 8'h00;
				hdr_slave_q    <= 8'h00;
				hdr_function_q <= 8'h00;
				hdr_count_q    <= 8'h00;
				overflow_q     <= 1'b0;
			end else begin
				crc_q          <= crc_n;
				byte_index_q   <= index_n;
				dly0_q         <= dly0_n;
				dly1_q         <= dly1_n;
				hdr_slave_q    <= hs_n;
				hdr_function_q <= hf_n;
				hdr_count_q    <= hc_n;
				overflow_q     <= overflow_q || over_now;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && produce) begin
			res_data_q <= res_data_n;
			res_user_q <= last_s1;
		end
	end

	// Checks
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_W'(MAX_FRAME_BYTES))
		else $error("byte index beyond frame limit");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> byte_index_q == IDX_W'(MAX_FRAME_BYTES))
		else $error("overflow flag set below frame limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |=> byte_index_q == '0 && crc_q == CRC_SEED && !overflow_q)
		else $error("frame state not cleared after last item");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_user_q |-> res_data_q[TDATA_W-1:8] == '0)
		else $error("payload result carries status fields");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && res_valid_q && !m_axis_tready)
		else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ===== dv/rtu_frame_checker.sv =====
`default_nettype none

module rtu_frame_checker
	import mrrc_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_axis_tvalid,
	input  wire                s_axis_tready,
	input  wire  [7:0]         s_axis_tdata,   // [7:0] rx_byte
	input  wire                s_axis_tlast,   // end_of_frame
	input  wire                m_axis_tvalid,
	input  wire                m_axis_tready,
	input  wire  [TDATA_W-1:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] frame_status,
	                                           // [18:11] exception_code,
	                                           // [19] function_mismatch,
	                                           // [27:20] payload_length
	input  wire                m_axis_tuser,   // [0] is_status
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [7:0]         cfg_data,
	output int unsigned        fail_count,
	output int unsigned        awaited_count
);

	typedef struct packed {
		logic       is_status;
		logic [7:0] payload_byte;
		status_t    frame_status;
		logic [7:0] exception_code;
		logic       function_mismatch;
		logic [7:0] payload_length;
	} frame_result_t;

	// Register copies
	logic [7:0] want_slave = 8'd1;
	logic [7:0] want_func  = 8'd3;

	// Frame state of the predictor
	logic [15:0] crc_acc   = CRC_SEED;
	logic [8:0]  octet_pos = '0;
	logic [7:0]  lag0      = '0;
	logic [7:0]  lag1      = '0;
	logic [7:0]  hdr_slave = '0;
	logic [7:0]  hdr_func  = '0;
	logic [7:0]  hdr_count = '0;
	logic        ovf       = 1'b0;

	frame_result_t results_due[$];
	frame_result_t due_item;
	frame_result_t seen_item;
	int unsigned   fails = 0;

	// Bit-serial CRC-16 update, least significant bit first
	function automatic logic [15:0] crc_byte_update(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb  = crc[0] ^ b[i];
			crc = crc >> 1;
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	function automatic void clear_frame();
		crc_acc   = CRC_SEED;
		octet_pos = '0;
		lag0      = '0;
		lag1      = '0;
		hdr_slave = '0;
		hdr_func  = '0;
		hdr_count = '0;
		ovf       = 1'b0;
	endfunction

	// Advance the frame state by one octet and queue the result it causes
	function automatic void predict_octet(input logic [7:0] octet, input logic last);
		frame_result_t r;
		logic          pass_on;
		int            span;
		r       = '0;
		pass_on = 1'b0;
		if (octet_pos >= MAX_FRAME_BYTES) begin
			ovf = 1'b1;
		end else begin
			// the CRC trails the input by two octets
			if (octet_pos >= 2) begin
				crc_acc = crc_byte_update(crc_acc, lag1);
			end
			lag1 = lag0;
			lag0 = octet;
			if (octet_pos == 0) begin
				hdr_slave = octet;
			end else if (octet_pos == 1) begin
				hdr_func = octet;
			end else if (octet_pos == 2) begin
				hdr_count = octet;
			end else if (octet_pos < 3 + hdr_count && hdr_func != FUNC_EXCEPTION) begin
				pass_on = 1'b1;
			end
			octet_pos = octet_pos + 1'b1;
		end

		if (!last) begin
			if (pass_on) begin
				r.payload_byte = octet;
				results_due.push_back(r);
			end
		end else begin
			span        = octet_pos;
			r.is_status = 1'b1;
			if (ovf) begin
				r.frame_status = ST_OVERFLOW;
			end else if (span < 4) begin
				r.frame_status = ST_TOO_SHORT;
			end else if (lag1 != crc_acc[7:0] || octet != crc_acc[15:8]) begin
				r.frame_status = ST_CRC_BAD;
			end else if (span < 5) begin
				r.frame_status = ST_TOO_SHORT;
			end else if (hdr_slave != want_slave) begin
				r.frame_status = ST_SLAVE_BAD;
			end else if (hdr_func == FUNC_EXCEPTION) begin
				r.frame_status   = ST_EXCEPTION;
				r.exception_code = hdr_count;
			end else begin
				r.function_mismatch = (hdr_func != want_func);
				if (hdr_count + 5 > span) begin
					r.frame_status = ST_PAYLOAD_SHORT;
				end else begin
					r.frame_status   = ST_OK;
					r.payload_length = hdr_count;
				end
			end
			results_due.push_back(r);
			clear_frame();
		end
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
			fails++;
		end
	endfunction

	// Track register writes, compare results, predict from accepted items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_slave = 8'd1;
			want_func  = 8'd3;
			clear_frame();
			results_due.delete();
			fail_count    <= 0;
			awaited_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SLAVE) begin
					want_slave = cfg_data;
				end else begin
					want_func = cfg_data;
				end
			end

			if (m_axis_tvalid && m_axis_tready) begin
				seen_item.is_status         = m_axis_tuser;
				seen_item.payload_byte      = m_axis_tdata[7:0];
				seen_item.frame_status      = status_t'(m_axis_tdata[10:8]);
				seen_item.exception_code    = m_axis_tdata[18:11];
				seen_item.function_mismatch = m_axis_tdata[19];
				seen_item.payload_length    = m_axis_tdata[27:20];
				if (results_due.size() == 0) begin
					$display("%0t: result with nothing awaited: tuser %0b tdata 0x%0h",
						$time, m_axis_tuser, m_axis_tdata);
					fails++;
				end else begin
					due_item = results_due.pop_front();
					check_field("is_status", due_item.is_status, seen_item.is_status);
					check_field("payload_byte", due_item.payload_byte, seen_item.payload_byte);
					check_field("frame_status", due_item.frame_status, seen_item.frame_status);
					check_field("exception_code", due_item.exception_code,
						seen_item.exception_code);
					check_field("function_mismatch", due_item.function_mismatch,
						seen_item.function_mismatch);
					check_field("payload_length", due_item.payload_length,
						seen_item.payload_length);
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				predict_octet(s_axis_tdata, s_axis_tlast);
			end

			fail_count    <= fails;
			awaited_count <= results_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
	import mrrc_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef logic [7:0] octet_q_t[$];

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	wire                s_axis_tready;
	logic [7:0]         s_axis_tdata  = '0;
	logic               s_axis_tlast  = 1'b0;
	wire                m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	wire  [TDATA_W-1:0] m_axis_tdata;
	wire                m_axis_tuser;
	logic               cfg_we        = 1'b0;
	logic               cfg_index     = CFG_SLAVE;
	logic [7:0]         cfg_data      = '0;

	int unsigned fail_count;
	int unsigned awaited_count;
	int          src_idle_pct = 26;
	int          dst_idle_pct = 84;
	int          octets_sent  = 0;
	int          quiet_cycles = 0;
	logic [7:0]  slave_now    = 8'd1;
	logic [7:0]  func_now     = 8'd3;
	octet_q_t    frame_buf;

	modbus_rtu_response_checker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	rtu_frame_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.awaited_count (awaited_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// CRC used to build well-formed frames
	function automatic logic [15:0] modbus_crc(input octet_q_t q);
		logic [15:0] crc;
		crc = 16'hFFFF;
		foreach (q[i]) begin
			crc = crc ^ {8'h00, q[i]};
			repeat (8) begin
				crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
			end
		end
		return crc;
	endfunction

	function automatic void seal_frame();
		logic [15:0] crc;
		crc = modbus_crc(frame_buf);
		frame_buf.push_back(crc[7:0]);
		frame_buf.push_back(crc[15:8]);
	endfunction

	function automatic void fill_random(input int len);
		repeat (len) frame_buf.push_back(8'($urandom));
	endfunction

	function automatic void build_response(input logic [7:0] slave, input logic [7:0] fn,
		input logic [7:0] count, input int body, input int extra);
		frame_buf.delete();
		frame_buf.push_back(slave);
		frame_buf.push_back(fn);
		frame_buf.push_back(count);
		fill_random(body + extra);
		seal_frame();
	endfunction

	// Offer one item, idling first at random, and hold it until taken
	task automatic send_octet(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		octets_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++) begin
			send_octet(frame_buf[i], i == frame_buf.size() - 1);
		end
	endtask

	// Hold the input until every awaited result has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_count != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [7:0] slave, input logic [7:0] fn);
		wait_drained();
		repeat (4) @(posedge clk);
		write_reg(CFG_SLAVE, slave);
		write_reg(CFG_FUNCTION, fn);
		slave_now = slave;
		func_now  = fn;
	endtask

	// Mostly well-formed responses with random content, the rest broken or noise
	function automatic void random_frame();
		int         kind;
		int         count;
		int         body;
		int         extra;
		int         len;
		int         pick;
		logic [7:0] fn;
		kind  = $urandom_range(99);
		count = ($urandom_range(99) == 0) ? 251 : $urandom_range(12);
		extra = (count < 251 && $urandom_range(9) == 0) ? $urandom_range(1, 4) : 0;
		fn    = ($urandom_range(4) == 0) ? 8'($urandom) : func_now;
		frame_buf.delete();
		if (kind < 55) begin
			build_response(slave_now, fn, 8'(count), count, extra);
		end else if (kind < 65) begin
			build_response(slave_now, FUNC_EXCEPTION, 8'($urandom), 0, extra);
		end else if (kind < 73) begin
			count = $urandom_range(1, 12);
			build_response(slave_now, fn, 8'(count), $urandom_range(count - 1), 0);
		end else if (kind < 81) begin
			build_response(slave_now, fn, 8'(count), count, extra);
			pick = frame_buf.size() - 1 - $urandom_range(1);
			frame_buf[pick] = frame_buf[pick] ^ 8'(1 << $urandom_range(7));
		end else if (kind < 87) begin
			build_response(slave_now ^ 8'($urandom_range(1, 255)), fn, 8'(count), count, 0);
		end else if (kind < 93) begin
			len = $urandom_range(1, 4);
			if (len == 4 && $urandom_range(1) == 1) begin
				fill_random(2);
				seal_frame();
			end else begin
				fill_random(len);
			end
		end else if (kind < 98) begin
			fill_random($urandom_range(1, 20));
		end else begin
			fill_random($urandom_range(257, 262));
		end
	endfunction

	initial begin
		int target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at reset register values
		frame_buf = '{8'h01, 8'h03, 8'h01, 8'hFF};
		seal_frame();
		send_frame();
		frame_buf = '{8'h00};
		send_frame();
		frame_buf = '{8'hFF, 8'hFF, 8'hFF};
		send_frame();
		frame_buf = '{8'h01, 8'h03};
		seal_frame();
		send_frame();
		frame_buf = '{8'h01, 8'h83, 8'h02};
		seal_frame();
		send_frame();
		frame_buf = '{8'h02, 8'h03, 8'h00};
		seal_frame();
		send_frame();

		// Random frames over three idling regimes and several register settings
		for (int phase = 0; phase < 3; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					src_idle_pct = 26;
					dst_idle_pct = 84;
				end
				1: begin
					src_idle_pct = 84;
					dst_idle_pct = 26;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				case ((phase * 3 + blk) % 4)
					0: apply_setting(8'h00, 8'hFF);
					1: apply_setting(8'hFF, 8'h00);
					2: apply_setting(8'($urandom), 8'($urandom));
					default: apply_setting(8'h01, 8'h03);
				endcase
				target = octets_sent + 220;
				while (octets_sent < target) begin
					if ($urandom_range(19) == 0) begin
						wait_drained();
					end
					random_frame();
					send_frame();
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && awaited_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
